// File: rtl/blpw_pkg.sv
`timescale 1ns / 1ps

package blpw_pkg;

  localparam int MAX_DIMENSION_DEFAULT = 2048;

  // frame registers are 12 bits, so an on-screen coordinate fits in 12 bits
  localparam int FRAME_REG_W = 12;
  localparam int COORD_W     = FRAME_REG_W;
  localparam int DIM_W       = FRAME_REG_W + 1;
  localparam int OFFSET_W    = 22;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // floor(v / 15) == (v * 274) >> 12 for every v up to 225
  localparam int          RECIP_W     = 9;
  localparam logic [8:0]  RECIP_15    = 9'd274;
  localparam int          RECIP_SHIFT = 12;
  localparam logic [3:0]  CHAN_MAX    = 4'hF;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_SCISSOR_EN   = 3'd2,
    CFG_SCISSOR_LEFT = 3'd3,
    CFG_SCISSOR_TOP  = 3'd4,
    CFG_SPAN_X       = 3'd5,
    CFG_SPAN_Y       = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic               mode;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [3:0]         red;
    logic [3:0]         green;
    logic [3:0]         blue;
    logic [3:0]         opacity;
    logic [15:0]        old_pixel;
  } pixel_req_t;

  typedef struct packed {
    logic                write_enable;
    logic [OFFSET_W-1:0] word_offset;
    logic [15:0]         pixel_value;
  } pixel_wr_t;

endpackage

// File: rtl/block_linear_pixel_blend_writer.sv
`timescale 1ns / 1ps

// Pixel writer for an RGBA4444 framebuffer in block-linear layout. Each accepted
// request yields exactly one result, in order: a dropped write (off-screen or
// outside an enabled, half-open scissor box) comes out with write_enable low and
// zero offset and pixel. In blend mode each color channel becomes
// floor((new*a + old*(15-a))/15) and alpha saturates at 15. The block takes one
// pixel per clock unless out_ready stalls it; its stages are bounds test and
// channel products, then reciprocal multiply for the divide by 15 together with
// the block-row stride multiply, then offset assembly into the output register.
// Each stage holds under back-pressure and fills bubbles independently.
// Configuration registers are written through cfg_write/cfg_index/cfg_data.
module block_linear_pixel_blend_writer #(
  parameter int MAX_DIMENSION = blpw_pkg::MAX_DIMENSION_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [blpw_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [blpw_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  blpw_pkg::pixel_req_t                   in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output blpw_pkg::pixel_wr_t                    out_data
);
  import blpw_pkg::*;

  localparam logic [DIM_W-1:0] DIM_CAP =
    (MAX_DIMENSION > (2 ** FRAME_REG_W) - 1) ? DIM_W'((2 ** FRAME_REG_W) - 1)
                                             : DIM_W'(MAX_DIMENSION);

  // configuration registers
  logic [FRAME_REG_W-1:0] frame_width;
  logic [FRAME_REG_W-1:0] frame_height;
  logic                   scissor_enable;
  logic signed [15:0]     scissor_left;
  logic signed [15:0]     scissor_top;
  logic [14:0]            scissor_span_x;
  logic [14:0]            scissor_span_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= FRAME_REG_W'(1280);
      frame_height   <= FRAME_REG_W'(720);
      scissor_enable <= 1'b0;
      scissor_left   <= '0;
      scissor_top    <= '0;
      scissor_span_x <= '0;
      scissor_span_y <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width    <= cfg_data[FRAME_REG_W-1:0];
        CFG_FRAME_HEIGHT: frame_height   <= cfg_data[FRAME_REG_W-1:0];
        CFG_SCISSOR_EN:   scissor_enable <= cfg_data[0];
        CFG_SCISSOR_LEFT: scissor_left   <= cfg_data;
        CFG_SCISSOR_TOP:  scissor_top    <= cfg_data;
        CFG_SPAN_X:       scissor_span_x <= cfg_data[14:0];
        CFG_SPAN_Y:       scissor_span_y <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0] width_clamped;
  logic [DIM_W-1:0] height_clamped;

  assign width_clamped  = ({1'b0, frame_width} > DIM_CAP) ? DIM_CAP : {1'b0, frame_width};
  assign height_clamped = ({1'b0, frame_height} > DIM_CAP) ? DIM_CAP : {1'b0, frame_height};

  // stage advance: a stage moves when it is empty or the next one takes its item
  logic en1, en2, en3;
  logic s1_valid, s2_valid, s3_valid;

  assign en3      = !s3_valid || out_ready;
  assign en2      = !s2_valid || en3;
  assign en1      = !s1_valid || en2;
  assign in_ready = en1;

  // ---------------- stage 1: visibility and channel products ----------------
  logic signed [16:0] px17, py17, sc_left17, sc_top17, sc_right17, sc_bottom17;
  logic               on_frame, in_scissor, visible;
  logic [7:0]         sum_r, sum_g, sum_b;
  logic [3:0]         inv_a, alpha_new;
  logic [4:0]         alpha_sum;

  assign px17        = {in_data.pos_x[15], in_data.pos_x};
  assign py17        = {in_data.pos_y[15], in_data.pos_y};
  assign sc_left17   = {scissor_left[15], scissor_left};
  assign sc_top17    = {scissor_top[15], scissor_top};
  assign sc_right17  = sc_left17 + $signed({2'b00, scissor_span_x});
  assign sc_bottom17 = sc_top17 + $signed({2'b00, scissor_span_y});

  assign on_frame = !in_data.pos_x[15] && !in_data.pos_y[15]
                 && (in_data.pos_x[14:0] < {2'b00, width_clamped})
                 && (in_data.pos_y[14:0] < {2'b00, height_clamped});
  assign in_scissor = (px17 >= sc_left17) && (px17 < sc_right17)
                   && (py17 >= sc_top17) && (py17 < sc_bottom17);
  assign visible = on_frame && (!scissor_enable || in_scissor);

  assign inv_a     = CHAN_MAX - in_data.opacity;
  assign alpha_sum = {1'b0, in_data.opacity} + {1'b0, in_data.old_pixel[15:12]};

  // direct mode scales by 15 so the shared divide returns the new channel unchanged
  always_comb begin
    if (in_data.mode) begin
      sum_r = in_data.red   * in_data.opacity + in_data.old_pixel[3:0]  * inv_a;
      sum_g = in_data.green * in_data.opacity + in_data.old_pixel[7:4]  * inv_a;
      sum_b = in_data.blue  * in_data.opacity + in_data.old_pixel[11:8] * inv_a;
      alpha_new = alpha_sum[4] ? CHAN_MAX : alpha_sum[3:0];
    end else begin
      sum_r = in_data.red   * CHAN_MAX;
      sum_g = in_data.green * CHAN_MAX;
      sum_b = in_data.blue  * CHAN_MAX;
      alpha_new = in_data.opacity;
    end
  end

  logic               s1_ok;
  logic [COORD_W-1:0] s1_x, s1_y;
  logic [7:0]         s1_sum_r, s1_sum_g, s1_sum_b;
  logic [3:0]         s1_alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en1) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_ok    <= visible;
      s1_x     <= in_data.pos_x[COORD_W-1:0];
      s1_y     <= in_data.pos_y[COORD_W-1:0];
      s1_sum_r <= sum_r;
      s1_sum_g <= sum_g;
      s1_sum_b <= sum_b;
      s1_alpha <= alpha_new;
    end
  end

  // ---------------- stage 2: divide by 15 and row stride ----------------
  logic [8+RECIP_W-1:0] q_r, q_g, q_b;
  logic [DIM_W-1:0]     stride_rows;

  assign q_r = s1_sum_r * RECIP_15;
  assign q_g = s1_sum_g * RECIP_15;
  assign q_b = s1_sum_b * RECIP_15;
  assign stride_rows = s1_y[COORD_W-1:7] * width_clamped[DIM_W-1:5];

  logic               s2_ok;
  logic [COORD_W-1:0] s2_x, s2_y;
  logic [3:0]         s2_r, s2_g, s2_b, s2_alpha;
  logic [DIM_W-1:0]   s2_stride;

  function automatic logic [DIM_W-1:0] s2_stride_next(input logic ok,
                                                      input logic [DIM_W-1:0] rows);
    return ok ? rows : '0;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_ok     <= s1_ok;
      s2_x      <= s1_x;
      s2_y      <= s1_y;
      s2_r      <= q_r[RECIP_SHIFT+3:RECIP_SHIFT];
      s2_g      <= q_g[RECIP_SHIFT+3:RECIP_SHIFT];
      s2_b      <= q_b[RECIP_SHIFT+3:RECIP_SHIFT];
      s2_alpha  <= s1_alpha;
      s2_stride <= s2_stride_next(s1_ok, stride_rows);
    end
  end

  // ---------------- stage 3: offset assembly and output register ----------------
  logic [15:0]          gob_base;
  logic [OFFSET_W-1:0]  offset_calc;

  assign gob_base = 16'(s2_y[6:4]) + 16'({s2_x[COORD_W-1:5], 3'b000})
                  + 16'({s2_stride, 3'b000});
  // 512-word unit = two 64x8-byte GOBs stacked; within it the bits interleave y and x
  assign offset_calc = {gob_base[12:0], s2_y[3], s2_x[4], s2_y[2:1], s2_x[3], s2_y[0],
                        s2_x[2:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en3) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      out_data.write_enable <= s2_ok;
      out_data.word_offset  <= s2_ok ? offset_calc : '0;
      out_data.pixel_value  <= s2_ok ? {s2_alpha, s2_b, s2_g, s2_r} : '0;
    end
  end

  assign out_valid = s3_valid;

  // ---------------- checks ----------------
  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.write_enable |->
      out_data.word_offset == '0 && out_data.pixel_value == '0)
    else $error("dropped write carries nonzero payload");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> s1_valid)
    else $error("accepted request missing from first stage");

  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !en3 |=> s2_valid && $stable(s2_r) && $stable(s2_stride) && $stable(s2_ok))
    else $error("second stage changed while stalled");

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import blpw_pkg::*;

  localparam int          MAX_DIM        = MAX_DIMENSION_DEFAULT;
  localparam int          CYCLE_LIMIT    = 200000;
  localparam logic        MODE_DIRECT    = 1'b0;
  localparam logic        MODE_BLEND     = 1'b1;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_UNUSED = 3'd7;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  pixel_req_t             in_data;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  pixel_wr_t              out_data;

  // shadow copy of the register file
  logic [11:0]        fb_width;
  logic [11:0]        fb_height;
  logic               sc_enable;
  logic signed [15:0] sc_left;
  logic signed [15:0] sc_top;
  logic [14:0]        sc_span_x;
  logic [14:0]        sc_span_y;

  pixel_wr_t pending_writes[$];
  int        mismatches = 0;
  int        cycle_count = 0;
  bit        src_idle = 1'b0;
  bit        sink_idle = 1'b0;
  int        sink_hold = 0;
  int        sink_gap = 0;

  block_linear_pixel_blend_writer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int eff_dim(input logic [11:0] v);
    return (v > MAX_DIM) ? MAX_DIM : int'(v);
  endfunction

  function automatic int unsigned blend_channel(input int unsigned oldc, input int unsigned newc,
                                                input int unsigned a);
    return (newc * a + oldc * (15 - a)) / 15;
  endfunction

  function automatic pixel_wr_t predict_write(input pixel_req_t req);
    pixel_wr_t   res;
    int          x, y, w, h, sl, st, sx, sy;
    int unsigned ux, uy, base, bytes, asum;
    logic [3:0]  r, g, b, a;
    bit          on;
    res = '0;
    w  = eff_dim(fb_width);
    h  = eff_dim(fb_height);
    x  = $signed(req.pos_x);
    y  = $signed(req.pos_y);
    sl = sc_left;
    st = sc_top;
    sx = sc_span_x;
    sy = sc_span_y;
    on = x >= 0 && y >= 0 && x < w && y < h;
    if (on && sc_enable)
      on = x >= sl && x < sl + sx && y >= st && y < st + sy;
    if (!on)
      return res;
    r = req.red;
    g = req.green;
    b = req.blue;
    a = req.opacity;
    if (req.mode == MODE_BLEND) begin
      asum = req.opacity + req.old_pixel[15:12];
      r = 4'(blend_channel(req.old_pixel[3:0], req.red, req.opacity));
      g = 4'(blend_channel(req.old_pixel[7:4], req.green, req.opacity));
      b = 4'(blend_channel(req.old_pixel[11:8], req.blue, req.opacity));
      a = (asum > 15) ? 4'hF : asum[3:0];
    end
    ux = x;
    uy = y;
    // 64x8-byte GOBs stacked 16 high, block rows strided by the frame width
    base  = ((uy & 127) / 16) + (ux / 32 * 8) + ((uy / 128) * ((w / 2) / 16 * 8));
    bytes = base * 1024 + ((uy % 16) / 8) * 512 + ((ux % 32) / 16) * 256
          + ((uy % 8) / 2) * 64 + ((ux % 16) / 8) * 32 + (uy % 2) * 16 + (ux % 8) * 2;
    res.write_enable = 1'b1;
    res.word_offset  = 22'(bytes / 2);
    res.pixel_value  = {a, b, g, r};
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h, expected %0h at cycle %0d", what, got, want, cycle_count);
    mismatches++;
  endtask

  always @(posedge clk) begin : check_writes
    pixel_wr_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_writes.size() == 0) begin
        report_mismatch("unexpected result", out_data.pixel_value, 32'h0);
      end else begin
        want = pending_writes.pop_front();
        if (out_data.write_enable !== want.write_enable)
          report_mismatch("write_enable", out_data.write_enable, want.write_enable);
        if (out_data.word_offset !== want.word_offset)
          report_mismatch("word_offset", out_data.word_offset, want.word_offset);
        if (out_data.pixel_value !== want.pixel_value)
          report_mismatch("pixel_value", out_data.pixel_value, want.pixel_value);
      end
    end
  end

  // receiver: long holds requested by a test, random stall bursts while sink_idle is set
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (sink_hold > 0) begin
      out_ready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else if (sink_gap > 0) begin
      out_ready <= 1'b0;
      sink_gap <= sink_gap - 1;
    end else if (sink_idle && $urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      sink_gap <= $urandom_range(0, 16);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_pixel(input pixel_req_t req);
    if (src_idle && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    pending_writes.push_back(predict_write(req));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic apply_config(input logic [15:0] w, input logic [15:0] h,
                              input logic [15:0] en, input logic [15:0] l,
                              input logic [15:0] t, input logic [15:0] sx,
                              input logic [15:0] sy);
    wait_idle();
    put_reg(CFG_FRAME_WIDTH, w);
    put_reg(CFG_FRAME_HEIGHT, h);
    put_reg(CFG_SCISSOR_EN, en);
    put_reg(CFG_SCISSOR_LEFT, l);
    put_reg(CFG_SCISSOR_TOP, t);
    put_reg(CFG_SPAN_X, sx);
    put_reg(CFG_SPAN_Y, sy);
    // an unmapped index must leave every register alone
    put_reg(CFG_IDX_UNUSED, 16'($urandom));
    cfg_write <= 1'b0;
    fb_width  = w[11:0];
    fb_height = h[11:0];
    sc_enable = en[0];
    sc_left   = l;
    sc_top    = t;
    sc_span_x = sx[14:0];
    sc_span_y = sy[14:0];
  endtask

  function automatic pixel_req_t make_pixel(input logic m, input int x, input int y,
                                            input logic [3:0] r, input logic [3:0] g,
                                            input logic [3:0] b, input logic [3:0] a,
                                            input logic [15:0] old);
    pixel_req_t p;
    p.mode      = m;
    p.pos_x     = 16'(x);
    p.pos_y     = 16'(y);
    p.red       = r;
    p.green     = g;
    p.blue      = b;
    p.opacity   = a;
    p.old_pixel = old;
    return p;
  endfunction

  // bias toward the frame and scissor edges, with some fully random values
  function automatic logic [15:0] pick_coord(input int lim, input int org, input int span);
    int c;
    case ($urandom_range(0, 11))
      0: c = $urandom;
      1: c = org - 1 + $urandom_range(0, 2);
      2: c = org + span - 1 + $urandom_range(0, 2);
      3: c = lim - 1 + $urandom_range(0, 1);
      4: c = $urandom_range(0, 1) - 1;
      5, 6: c = org + $urandom_range(0, span > 0 ? span - 1 : 0);
      default: c = $urandom_range(0, lim > 0 ? lim - 1 : 0);
    endcase
    return c[15:0];
  endfunction

  function automatic pixel_req_t random_pixel();
    pixel_req_t p;
    p.mode      = 1'($urandom_range(0, 1));
    p.pos_x     = pick_coord(eff_dim(fb_width), sc_left, sc_span_x);
    p.pos_y     = pick_coord(eff_dim(fb_height), sc_top, sc_span_y);
    p.red       = 4'($urandom_range(0, 15));
    p.green     = 4'($urandom_range(0, 15));
    p.blue      = 4'($urandom_range(0, 15));
    p.opacity   = 4'($urandom_range(0, 15));
    p.old_pixel = 16'($urandom);
    return p;
  endfunction

  // upper bits beyond the register width may be random and must be dropped
  function automatic logic [15:0] pick_dim();
    case ($urandom_range(0, 9))
      0: return {4'($urandom), 12'h800};
      1: return {4'($urandom), 12'($urandom_range(2049, 4095))};
      2: return 16'($urandom_range(1, 8));
      3: return {4'($urandom), 12'h000};
      default: return 16'($urandom_range(1, 2048));
    endcase
  endfunction

  function automatic logic [15:0] pick_edge(input int lim);
    if ($urandom_range(0, 5) == 0)
      return 16'($urandom);
    return 16'($urandom_range(0, lim + 8) - 4);
  endfunction

  function automatic logic [15:0] pick_span(input int lim);
    case ($urandom_range(0, 7))
      0: return {1'($urandom), 15'h0000};
      1: return {1'($urandom), 15'h7FFF};
      default: return {1'($urandom), 15'($urandom_range(1, lim + 8))};
    endcase
  endfunction

  task automatic random_config();
    logic [15:0] w, h;
    w = pick_dim();
    h = pick_dim();
    apply_config(w, h, 16'($urandom), pick_edge(eff_dim(w[11:0])), pick_edge(eff_dim(h[11:0])),
                 pick_span(eff_dim(w[11:0])), pick_span(eff_dim(h[11:0])));
  endtask

  // reset values: 1280x720, scissor off
  task automatic test_reset_defaults();
    send_pixel(make_pixel(MODE_DIRECT, 0, 0, 4'h0, 4'h0, 4'h0, 4'h0, 16'h0000));
    send_pixel(make_pixel(MODE_DIRECT, 1279, 719, 4'hF, 4'hF, 4'hF, 4'hF, 16'hFFFF));
    send_pixel(make_pixel(MODE_DIRECT, 1280, 0, 4'h3, 4'h4, 4'h5, 4'h6, 16'h1234));
    send_pixel(make_pixel(MODE_DIRECT, 0, 720, 4'h3, 4'h4, 4'h5, 4'h6, 16'h1234));
    send_pixel(make_pixel(MODE_DIRECT, -1, 5, 4'h1, 4'h2, 4'h3, 4'h4, 16'h0000));
    send_pixel(make_pixel(MODE_BLEND, -32768, 32767, 4'hF, 4'hF, 4'hF, 4'hF, 16'hFFFF));
    send_pixel(make_pixel(MODE_BLEND, 32767, -32768, 4'hF, 4'hF, 4'hF, 4'hF, 16'hFFFF));
    // zero alpha keeps the old color; full alpha with full old alpha saturates
    send_pixel(make_pixel(MODE_BLEND, 37, 133, 4'hF, 4'hF, 4'hF, 4'h0, 16'h5A3C));
    send_pixel(make_pixel(MODE_BLEND, 100, 200, 4'h1, 4'h8, 4'hE, 4'hF, 16'hF0F0));
    send_pixel(make_pixel(MODE_BLEND, 515, 300, 4'h9, 4'h3, 4'hC, 4'h7, 16'h8E61));
  endtask

  task automatic test_frame_limits();
    apply_config(16'd1, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_pixel(make_pixel(MODE_DIRECT, 0, 0, 4'hA, 4'h5, 4'hA, 4'h5, 16'h0000));
    send_pixel(make_pixel(MODE_DIRECT, 0, 1, 4'hA, 4'h5, 4'hA, 4'h5, 16'h0000));
    // width register above the maximum is clamped for bounds and stride
    apply_config(16'hFFFF, 16'hF800, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_pixel(make_pixel(MODE_DIRECT, 2047, 2047, 4'h1, 4'h2, 4'h4, 4'h8, 16'h0000));
    send_pixel(make_pixel(MODE_DIRECT, 2048, 100, 4'h1, 4'h2, 4'h4, 4'h8, 16'h0000));
    send_pixel(make_pixel(MODE_BLEND, 100, 2048, 4'h1, 4'h2, 4'h4, 4'h8, 16'h0000));
    apply_config(16'd0, 16'd16, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_pixel(make_pixel(MODE_DIRECT, 0, 0, 4'hF, 4'hF, 4'hF, 4'hF, 16'h0000));
  endtask

  task automatic test_scissor();
    apply_config(16'd640, 16'd480, 16'd1, -16'sd5, -16'sd5, 16'd10, 16'd10);
    send_pixel(make_pixel(MODE_DIRECT, 4, 4, 4'h7, 4'h7, 4'h7, 4'h7, 16'h0000));
    send_pixel(make_pixel(MODE_DIRECT, 5, 0, 4'h7, 4'h7, 4'h7, 4'h7, 16'h0000));
    send_pixel(make_pixel(MODE_DIRECT, 0, 5, 4'h7, 4'h7, 4'h7, 4'h7, 16'h0000));
    send_pixel(make_pixel(MODE_BLEND, 0, 0, 4'h7, 4'h7, 4'h7, 4'h7, 16'h7777));
    // empty box drops everything while enabled
    apply_config(16'd640, 16'd480, 16'd1, 16'd100, 16'd50, 16'd0, 16'h7FFF);
    send_pixel(make_pixel(MODE_DIRECT, 100, 60, 4'h7, 4'h7, 4'h7, 4'h7, 16'h0000));
    apply_config(16'd2048, 16'd2048, 16'hFFFF, 16'h8000, 16'h8000, 16'hFFFF, 16'h7FFF);
    send_pixel(make_pixel(MODE_DIRECT, 0, 0, 4'h7, 4'h7, 4'h7, 4'h7, 16'h0000));
    send_pixel(make_pixel(MODE_DIRECT, 2047, 2047, 4'h7, 4'h7, 4'h7, 4'h7, 16'h0000));
  endtask

  // stall the receiver long enough that the pipeline backs up into the input
  task automatic test_backpressure();
    random_config();
    src_idle  = 1'b0;
    sink_hold = 200;
    repeat (80) send_pixel(random_pixel());
    wait_idle();
  endtask

  task automatic test_random_phases();
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    repeat (9) begin
      random_config();
      repeat (80) send_pixel(random_pixel());
    end
  endtask

  task automatic test_streaming();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    random_config();
    repeat (100) send_pixel(random_pixel());
  endtask

  initial begin
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    fb_width  = 12'd1280;
    fb_height = 12'd720;
    sc_enable = 1'b0;
    sc_left   = '0;
    sc_top    = '0;
    sc_span_x = '0;
    sc_span_y = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_frame_limits();
    test_scissor();
    test_backpressure();
    test_random_phases();
    test_streaming();
    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: sim.f
rtl/blpw_pkg.sv
rtl/block_linear_pixel_blend_writer.sv
verif/tb_top.sv
